// File: rtl/dtt_pkg.sv
// Shared types and codes for the deadline timer table.
`default_nettype none

package dtt_pkg;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // input command codes
  localparam logic [1:0] CMD_SCHED  = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_ELAPSE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_FIRED = 2'd2;

  // command as queued between front and back; elapsed time already normalized
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  kind;
    logic [15:0] iface;
    logic [15:0] delay;
    logic [16:0] esec;
    logic [29:0] ensec;
  } cmd_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] iface;
    logic [15:0] sec;
    logic [29:0] nsec;
  } ent_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  kind;
    logic [15:0] iface;
    logic        last;
    logic        pend;
    logic [15:0] sec;
    logic [29:0] nsec;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/deadline_timer_table.sv
// Top level of the deadline timer table.
//
//   channel  handshake             accept when     beats per item
//   input    push / full           push && !full   1
//   result   empty / pop           pop && !empty   1 .. TASKS
//
// Each command runs two passes over the entry memory (update, then earliest
// deadline), one entry per cycle, then gives one result beat per fired timer,
// or a single beat when no timer fires.
// The entry memory, with one read port and one write port, paces both passes.
// Reset is synchronous; it clears all valid bits, so the table starts empty.
// Two commands queue ahead of the back end and two results queue at the
// output; a stalled pop holds the back end without losing input beats.
`default_nettype none

module deadline_timer_table import dtt_pkg::*; #(
  parameter int TASKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_task_kind,
  input  wire logic [15:0] in_iface,
  input  wire logic [15:0] in_delay_sec,
  input  wire logic [15:0] in_elapsed_sec,
  input  wire logic [29:0] in_elapsed_nsec,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_status,
  output logic [3:0]       out_fired_kind,
  output logic [15:0]      out_fired_iface,
  output logic             out_last,
  output logic             out_any_pending,
  output logic [15:0]      out_next_sec,
  output logic [29:0]      out_next_nsec
);

  logic q_valid;
  cmd_t q_item;
  logic q_take;
  logic res_valid;
  res_t res;
  logic res_ready;

  dtt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_task_kind    (in_task_kind),
    .in_iface        (in_iface),
    .in_delay_sec    (in_delay_sec),
    .in_elapsed_sec  (in_elapsed_sec),
    .in_elapsed_nsec (in_elapsed_nsec),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_take          (q_take)
  );

  dtt_back #(
    .TASKS (TASKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  dtt_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .empty           (empty),
    .pop             (pop),
    .out_status      (out_status),
    .out_fired_kind  (out_fired_kind),
    .out_fired_iface (out_fired_iface),
    .out_last        (out_last),
    .out_any_pending (out_any_pending),
    .out_next_sec    (out_next_sec),
    .out_next_nsec   (out_next_nsec)
  );

endmodule

`default_nettype wire

// File: rtl/dtt_front.sv
// Front end: takes input beats, normalizes elapsed time, queues commands.
`default_nettype none

module dtt_front import dtt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_task_kind,
  input  wire logic [15:0] in_iface,
  input  wire logic [15:0] in_delay_sec,
  input  wire logic [15:0] in_elapsed_sec,
  input  wire logic [29:0] in_elapsed_nsec,
  output logic             q_valid,
  output cmd_t             q_item,
  input  wire logic        q_take
);

  cmd_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  cmd_t       item;
  logic       ns_ovf;
  logic       do_push;
  logic       do_pop;

  // nanoseconds of a second or more carry into seconds; value < 2^30 so one step
  always_comb begin
    ns_ovf      = (in_elapsed_nsec >= NS_PER_SEC);
    item.op     = in_cmd;
    item.kind   = in_task_kind;
    item.iface  = in_iface;
    item.delay  = in_delay_sec;
    item.esec   = {1'b0, in_elapsed_sec} + {16'd0, ns_ovf};
    item.ensec  = ns_ovf ? (in_elapsed_nsec - NS_PER_SEC) : in_elapsed_nsec;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/dtt_back.sv
// Back end: entry memory, table scans, schedule update and result sequencing.
`default_nettype none

module dtt_back import dtt_pkg::*; #(
  parameter int TASKS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_item,
  output logic      q_take,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_APPLY    = 3'd2;
  localparam logic [2:0] S_MIN      = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_OUT = 3'd5;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  cmd_t             cur_r;
  logic [TASKS-1:0] valid_r;
  logic [TASKS-1:0] fire_r;
  logic [CW-1:0]    cnt_r;
  logic             dv_r;
  logic [IW-1:0]    di_r;

  ent_t             mem [TASKS];
  ent_t             rd_r;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  ent_t             mem_wd;

  logic             match_r;
  logic [IW-1:0]    match_idx_r;
  logic [15:0]      match_sec_r;
  logic             match_nz_r;
  logic             free_r;
  logic [IW-1:0]    free_idx_r;
  logic [1:0]       status_r;
  logic             pend_r;
  logic [15:0]      best_sec_r;
  logic [29:0]      best_nsec_r;
  logic [IW-1:0]    cur_idx_r;
  logic             last_r;
  logic             fired_out_r;

  logic             scan_issue;
  logic             scan_done;
  logic [16:0]      rs17;
  logic             gt;
  logic             brw;
  logic [30:0]      ns_sum;
  logic [16:0]      ss;
  logic [15:0]      new_sec;
  logic [29:0]      new_nsec;
  logic [16:0]      old_up;
  logic             keep;
  logic             less;
  logic [IW-1:0]    ffs;
  logic [TASKS-1:0] ffs_oh;
  logic [IW-1:0]    slot;

  assign scan_issue = (cnt_r < CW'(TASKS));
  assign scan_done  = !scan_issue && !dv_r;
  assign q_take     = (state_r == S_IDLE) && q_valid;

  // remaining time minus elapsed time, clamped at zero
  always_comb begin
    rs17     = {1'b0, rd_r.sec};
    gt       = (rs17 > cur_r.esec) || ((rs17 == cur_r.esec) && (rd_r.nsec > cur_r.ensec));
    brw      = (rd_r.nsec < cur_r.ensec);
    ns_sum   = {1'b0, rd_r.nsec} + (brw ? {1'b0, NS_PER_SEC} : 31'd0) - {1'b0, cur_r.ensec};
    ss       = rs17 - cur_r.esec - {16'd0, brw};
    new_sec  = gt ? ss[15:0] : 16'd0;
    new_nsec = gt ? ns_sum[29:0] : 30'd0;
  end

  // existing deadline, rounded up to whole seconds, already no later than the request
  always_comb begin
    old_up = {1'b0, match_sec_r} + {16'd0, match_nz_r};
    keep   = match_r && ((match_sec_r != 16'd0) || match_nz_r)
             && (old_up <= {1'b0, cur_r.delay});
    slot   = match_r ? match_idx_r : free_idx_r;
  end

  assign less = (rd_r.sec < best_sec_r)
                || ((rd_r.sec == best_sec_r) && (rd_r.nsec < best_nsec_r));

  // lowest fired entry first
  always_comb begin
    ffs = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (fire_r[i]) begin
        ffs = IW'(i);
      end
    end
    ffs_oh = {{(TASKS-1){1'b0}}, 1'b1} << ffs;
  end

  always_comb begin
    unique case (state_r)
      S_EMIT_RD:  rd_addr = ffs;
      S_EMIT_OUT: rd_addr = cur_idx_r;
      default:    rd_addr = cnt_r[IW-1:0];
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = di_r;
    mem_wd = rd_r;
    if (state_r == S_SCAN && dv_r && cur_r.op == CMD_ELAPSE && valid_r[di_r]) begin
      mem_we      = 1'b1;
      mem_wd.sec  = new_sec;
      mem_wd.nsec = new_nsec;
    end else if (state_r == S_APPLY && cur_r.op == CMD_SCHED && (match_r || free_r) && !keep) begin
      mem_we = 1'b1;
      mem_wa = slot;
      mem_wd = '{kind: cur_r.kind, iface: cur_r.iface, sec: cur_r.delay, nsec: 30'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (q_valid) state_nxt = S_SCAN;
      S_SCAN:     if (scan_done) state_nxt = S_APPLY;
      S_APPLY:    state_nxt = S_MIN;
      S_MIN:      if (scan_done) state_nxt = (fire_r != '0) ? S_EMIT_RD : S_EMIT_OUT;
      S_EMIT_RD:  state_nxt = S_EMIT_OUT;
      S_EMIT_OUT: if (res_ready) state_nxt = last_r ? S_IDLE : S_EMIT_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      fire_r      <= '0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      pend_r      <= 1'b0;
      last_r      <= 1'b0;
      fired_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r    <= q_item;
            cnt_r    <= '0;
            dv_r     <= 1'b0;
            match_r  <= 1'b0;
            free_r   <= 1'b0;
            fire_r   <= '0;
            status_r <= STAT_DONE;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            cnt_r <= cnt_r + CW'(1);
          end
          dv_r <= scan_issue;
          di_r <= cnt_r[IW-1:0];
          if (dv_r) begin
            case (cur_r.op)
              CMD_SCHED: begin
                if (valid_r[di_r] && rd_r.kind == cur_r.kind && rd_r.iface == cur_r.iface
                    && !match_r) begin
                  match_r     <= 1'b1;
                  match_idx_r <= di_r;
                  match_sec_r <= rd_r.sec;
                  match_nz_r  <= (rd_r.nsec != 30'd0);
                end
                if (!valid_r[di_r] && !free_r) begin
                  free_r     <= 1'b1;
                  free_idx_r <= di_r;
                end
              end
              CMD_CANCEL: begin
                if (rd_r.iface == cur_r.iface) begin
                  valid_r[di_r] <= 1'b0;
                end
              end
              CMD_ELAPSE: begin
                if (valid_r[di_r] && !gt) begin
                  valid_r[di_r] <= 1'b0;
                  fire_r[di_r]  <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_APPLY: begin
          if (cur_r.op == CMD_SCHED) begin
            if (!match_r && !free_r) begin
              status_r <= STAT_FULL;
            end else if (!keep) begin
              valid_r[slot] <= 1'b1;
            end
          end
          cnt_r       <= '0;
          dv_r        <= 1'b0;
          pend_r      <= 1'b0;
          best_sec_r  <= 16'd0;
          best_nsec_r <= 30'd0;
        end
        S_MIN: begin
          if (scan_issue) begin
            cnt_r <= cnt_r + CW'(1);
          end
          dv_r <= scan_issue;
          di_r <= cnt_r[IW-1:0];
          if (dv_r && valid_r[di_r] && (!pend_r || less)) begin
            pend_r      <= 1'b1;
            best_sec_r  <= rd_r.sec;
            best_nsec_r <= rd_r.nsec;
          end
          if (scan_done && fire_r == '0) begin
            last_r      <= 1'b1;
            fired_out_r <= 1'b0;
          end
        end
        S_EMIT_RD: begin
          cur_idx_r   <= ffs;
          fire_r      <= fire_r & ~ffs_oh;
          last_r      <= ((fire_r & ~ffs_oh) == '0);
          fired_out_r <= 1'b1;
        end
        S_EMIT_OUT: ;
        default: ;
      endcase
    end
  end

  assign res_valid = (state_r == S_EMIT_OUT);

  always_comb begin
    res.status = fired_out_r ? STAT_FIRED : status_r;
    res.kind   = fired_out_r ? rd_r.kind : 4'd0;
    res.iface  = fired_out_r ? rd_r.iface : 16'd0;
    res.last   = last_r;
    res.pend   = pend_r;
    res.sec    = best_sec_r;
    res.nsec   = best_nsec_r;
  end

endmodule

`default_nettype wire

// File: rtl/dtt_outq.sv
// Two-deep result queue that drives the output ports.
`default_nettype none

module dtt_outq import dtt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         res_valid,
  input  wire res_t         res,
  output logic              res_ready,
  output logic              empty,
  input  wire logic         pop,
  output logic [1:0]        out_status,
  output logic [3:0]        out_fired_kind,
  output logic [15:0]       out_fired_iface,
  output logic              out_last,
  output logic              out_any_pending,
  output logic [15:0]       out_next_sec,
  output logic [29:0]       out_next_nsec
);

  res_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;
  res_t       head;

  assign res_ready = (cnt_r != 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign do_push   = res_valid && res_ready;
  assign do_pop    = pop && !empty;
  assign head      = q_r[rp_r];

  assign out_status      = head.status;
  assign out_fired_kind  = head.kind;
  assign out_fired_iface = head.iface;
  assign out_last        = head.last;
  assign out_any_pending = head.pend;
  assign out_next_sec    = head.sec;
  assign out_next_nsec   = head.nsec;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: verif/deadline_timer_table_tb.sv
// Self-checking testbench for the deadline timer table: directed rows, then random commands.
`timescale 1ns / 100ps

module deadline_timer_table_tb import dtt_pkg::*; ();

  localparam int TASKS = 8;
  localparam longint unsigned TB_NS = 64'd1000000000;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 39;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  kind;
    logic [15:0] iface;
    logic [15:0] delay;
    logic [15:0] esec;
    logic [29:0] ensec;
    logic        typed;
    res_t        want;
  } stim_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_cmd = CMD_NOP;
  logic [3:0]  in_task_kind = '0;
  logic [15:0] in_iface = '0;
  logic [15:0] in_delay_sec = '0;
  logic [15:0] in_elapsed_sec = '0;
  logic [29:0] in_elapsed_nsec = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_fired_kind;
  logic [15:0] out_fired_iface;
  logic        out_last;
  logic        out_any_pending;
  logic [15:0] out_next_sec;
  logic [29:0] out_next_nsec;

  // shadow copy of the timer table
  logic        tmr_valid [TASKS];
  logic [3:0]  tmr_kind  [TASKS];
  logic [15:0] tmr_iface [TASKS];
  logic [15:0] tmr_sec   [TASKS];
  logic [29:0] tmr_nsec  [TASKS];

  res_t  expected_beats[$];
  res_t  fired_beats[$];
  stim_t offered_items[$];
  stim_t directed_rows[$];

  int fail_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_req = 0;
  res_t  want_beat;
  stim_t taken_item;

  deadline_timer_table #(.TASKS(TASKS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_cmd(in_cmd), .in_task_kind(in_task_kind), .in_iface(in_iface),
    .in_delay_sec(in_delay_sec), .in_elapsed_sec(in_elapsed_sec),
    .in_elapsed_nsec(in_elapsed_nsec),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_fired_kind(out_fired_kind),
    .out_fired_iface(out_fired_iface), .out_last(out_last),
    .out_any_pending(out_any_pending), .out_next_sec(out_next_sec),
    .out_next_nsec(out_next_nsec)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_timer(input int i);
    tmr_valid[i] = 1'b0;
    tmr_kind[i]  = '0;
    tmr_iface[i] = '0;
    tmr_sec[i]   = '0;
    tmr_nsec[i]  = '0;
  endtask

  // Applies one command to the shadow table and queues the beats it yields.
  task automatic predict_timers(input logic [1:0] cmd, input logic [3:0] kind,
                                input logic [15:0] ifc, input logic [15:0] delay,
                                input logic [15:0] esec, input logic [29:0] ensec,
                                input logic typed, input res_t want);
    int slot;
    int unsigned round_up;
    logic [1:0] status;
    longint unsigned el, t, best, e_sec, e_nsec;
    bit pend;
    res_t b;
    fired_beats.delete();
    status = STAT_DONE;
    slot = -1;
    pend = 0;
    best = 0;
    case (cmd)
      CMD_SCHED: begin
        for (int i = 0; i < TASKS && slot < 0; i++)
          if (tmr_valid[i] && tmr_kind[i] == kind && tmr_iface[i] == ifc) slot = i;
        for (int i = 0; i < TASKS && slot < 0; i++)
          if (!tmr_valid[i]) slot = i;
        if (slot < 0) begin
          status = STAT_FULL;
        end else begin
          round_up = (tmr_nsec[slot] != 0) ? 1 : 0;
          // an earlier or equal deadline already pending wins, partial seconds count as whole
          if (!(tmr_valid[slot] && (tmr_sec[slot] != 0 || tmr_nsec[slot] != 0) &&
                (int'(tmr_sec[slot]) + round_up <= int'(delay)))) begin
            tmr_valid[slot] = 1'b1;
            tmr_kind[slot]  = kind;
            tmr_iface[slot] = ifc;
            tmr_sec[slot]   = delay;
            tmr_nsec[slot]  = '0;
          end
        end
      end
      CMD_CANCEL: begin
        for (int i = 0; i < TASKS; i++)
          if (tmr_iface[i] == ifc) clear_timer(i);
      end
      CMD_ELAPSE: begin
        e_sec = 64'(esec);
        e_nsec = 64'(ensec);
        el = e_sec * TB_NS + e_nsec;
        for (int i = 0; i < TASKS; i++) begin
          if (tmr_valid[i]) begin
            e_sec = 64'(tmr_sec[i]);
            e_nsec = 64'(tmr_nsec[i]);
            t = e_sec * TB_NS + e_nsec;
            t = (t > el) ? t - el : 64'd0;
            tmr_sec[i] = 16'(t / TB_NS);
            tmr_nsec[i] = 30'(t % TB_NS);
            if (t == 0) begin
              b = '0;
              b.status = STAT_FIRED;
              b.kind = tmr_kind[i];
              b.iface = tmr_iface[i];
              fired_beats.push_back(b);
              tmr_valid[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    if (fired_beats.size() == 0) begin
      b = '0;
      b.status = status;
      fired_beats.push_back(b);
    end
    for (int i = 0; i < TASKS; i++) begin
      if (tmr_valid[i]) begin
        e_sec = 64'(tmr_sec[i]);
        e_nsec = 64'(tmr_nsec[i]);
        t = e_sec * TB_NS + e_nsec;
        if (!pend || t < best) best = t;
        pend = 1;
      end
    end
    if (typed) begin
      expected_beats.push_back(want);
    end else begin
      for (int k = 0; k < fired_beats.size(); k++) begin
        b = fired_beats[k];
        b.last = (k == fired_beats.size() - 1);
        b.pend = pend;
        b.sec  = 16'(best / TB_NS);
        b.nsec = 30'(best % TB_NS);
        expected_beats.push_back(b);
      end
    end
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [3:0] kind,
                         input logic [15:0] ifc, input logic [15:0] delay,
                         input logic [15:0] esec, input logic [29:0] ensec,
                         input logic typed, input logic [1:0] status,
                         input logic pend, input logic [15:0] sec,
                         input logic [29:0] nsec);
    stim_t s;
    s = '0;
    s.cmd = cmd;
    s.kind = kind;
    s.iface = ifc;
    s.delay = delay;
    s.esec = esec;
    s.ensec = ensec;
    s.typed = typed;
    s.want.status = status;
    s.want.last = 1'b1;
    s.want.pend = pend;
    s.want.sec = sec;
    s.want.nsec = nsec;
    directed_rows.push_back(s);
  endtask

  // Mostly a small key space so entries get reused, fill up and fire.
  function automatic stim_t random_item();
    stim_t s;
    int r, pick;
    s = '0;
    s.kind = 4'($urandom);
    s.iface = 16'($urandom);
    s.delay = 16'($urandom);
    s.esec = 16'($urandom);
    s.ensec = 30'($urandom);
    r = int'($urandom_range(99));
    pick = int'($urandom_range(9));
    if (r < 48) begin
      s.cmd = CMD_SCHED;
      if ($urandom_range(9) < 7) s.kind = 4'($urandom_range(3));
      if ($urandom_range(9) < 8) s.iface = 16'($urandom_range(3));
      if (pick < 6) s.delay = 16'($urandom_range(6));
      else if (pick < 8) s.delay = 16'($urandom_range(40));
      else if (pick == 9) s.delay = 16'hFFFF;
    end else if (r < 82) begin
      s.cmd = CMD_ELAPSE;
      if (pick < 7) s.esec = 16'($urandom_range(2));
      else if (pick < 9) s.esec = 16'($urandom_range(20));
      else if ($urandom_range(1)) s.esec = 16'hFFFF;
      pick = int'($urandom_range(9));
      if (pick < 8) s.ensec = 30'($urandom_range(999999999));
      else if (pick == 8) s.ensec = 30'($urandom_range(32'h3FFFFFFF));
      else s.ensec = $urandom_range(1) ? 30'd999999999 : 30'd0;
    end else if (r < 96) begin
      s.cmd = CMD_CANCEL;
      if ($urandom_range(99) < 85) s.iface = 16'($urandom_range(3));
    end else begin
      s.cmd = CMD_NOP;
    end
    return s;
  endfunction

  task automatic send_item(input stim_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    offered_items.push_back(s);
    push            <= 1'b1;
    in_cmd          <= s.cmd;
    in_task_kind    <= s.kind;
    in_iface        <= s.iface;
    in_delay_sec    <= s.delay;
    in_elapsed_sec  <= s.esec;
    in_elapsed_nsec <= s.ensec;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // input beat accepted: update the shadow table
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      taken_item = offered_items.pop_front();
      predict_timers(in_cmd, in_task_kind, in_iface, in_delay_sec, in_elapsed_sec,
                     in_elapsed_nsec, taken_item.typed, taken_item.want);
    end
  end

  // result beat accepted: compare with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual status %0d",
                 $time, out_status);
        fail_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("status", 64'(want_beat.status), 64'(out_status));
        check_field("fired_kind", 64'(want_beat.kind), 64'(out_fired_kind));
        check_field("fired_iface", 64'(want_beat.iface), 64'(out_fired_iface));
        check_field("last", 64'(want_beat.last), 64'(out_last));
        check_field("any_pending", 64'(want_beat.pend), 64'(out_any_pending));
        check_field("next_sec", 64'(want_beat.sec), 64'(out_next_sec));
        check_field("next_nsec", 64'(want_beat.nsec), 64'(out_next_nsec));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TASKS; i++) clear_timer(i);
    add_row(CMD_NOP,    0, 0,       0,       0,     0,            1, STAT_DONE, 0, 0, 0);
    add_row(CMD_ELAPSE, 0, 0,       0,       0,     0,            1, STAT_DONE, 0, 0, 0);
    add_row(CMD_CANCEL, 0, 0,       0,       0,     0,            1, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  15, 16'hFFFF, 16'hFFFF, 0, 0,             1, STAT_DONE, 1,
            16'hFFFF, 0);
    // zero delay: pending at once, fires on the next elapse
    add_row(CMD_SCHED,  0, 0,       0,       0,     0,            1, STAT_DONE, 1, 0, 0);
    add_row(CMD_ELAPSE, 0, 0,       0,       0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  15, 16'hFFFF, 100,   0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  15, 16'hFFFF, 200,   0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_ELAPSE, 0, 0,       0,       0,     999999999,    0, STAT_DONE, 0, 0, 0);
    // 99 s plus a few ns rounds up to 100: kept, then replaced by 99
    add_row(CMD_SCHED,  15, 16'hFFFF, 100,   0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  15, 16'hFFFF, 99,    0,     0,            0, STAT_DONE, 0, 0, 0);
    // nanoseconds beyond one second carry into seconds
    add_row(CMD_ELAPSE, 0, 0,       0,       0,     30'h3FFFFFFF, 0, STAT_DONE, 0, 0, 0);
    for (int k = 1; k < TASKS; k++)
      add_row(CMD_SCHED, 4'(k), 2,  5,       0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  9, 3,       5,       0,     0,            1, STAT_FULL, 1, 5, 0);
    add_row(CMD_CANCEL, 0, 2,       0,       0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  1, 4,       3,       0,     0,            0, STAT_DONE, 0, 0, 0);
    add_row(CMD_SCHED,  2, 4,       3,       0,     0,            0, STAT_DONE, 0, 0, 0);
    // overshoot clears everything, firing in table order
    add_row(CMD_ELAPSE, 0, 0,       0,       16'hFFFF, 0,         0, STAT_DONE, 0, 0, 0);
    add_row(CMD_ELAPSE, 0, 0,       0,       0,     0,            1, STAT_DONE, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin sender_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 10) hold_off_req = 1;
        send_item(random_item());
      end
    end
    push <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
